### src/qcsd_pkg.sv
package qcsd_pkg;

   // Field and register widths
   localparam int CountW = 16;
   localparam int PosW   = 32;
   localparam int BandW  = 15;
   localparam int DivW   = 8;

   // Width of the divider step counter
   localparam int StepW  = $clog2(CountW + 1);

   // Event limit per sample and the width of the event counter
   localparam int MaxEvents = 16;
   localparam int CntW      = $clog2(MaxEvents + 1);

   // Register indexes of the configuration port
   localparam logic [0:0] CSR_DEAD_BAND    = 1'b0;
   localparam logic [0:0] CSR_STEP_DIVIDER = 1'b1;

   // Reset values of the registers
   localparam logic [BandW-1:0] DeadBandReset    = BandW'(1);
   localparam logic [DivW-1:0]  StepDividerReset = DivW'(4);

   // Operation codes of an input beat
   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_SET_POS = 1'b1;

   typedef struct packed {
      logic                   func;
      logic signed [CountW-1:0] count;
      logic signed [PosW-1:0] new_position;
   } req_type;

   typedef struct packed {
      logic                   direction;
      logic signed [PosW-1:0] position;
      logic                   last;
   } rsp_type;

   // Quotient and remainder magnitudes from the serial divider
   typedef struct packed {
      logic [CountW-1:0] quo;
      logic [DivW-1:0]   rem;
   } div_res_type;

   // Burst of events handed to the emitter
   typedef struct packed {
      logic            direction;
      logic [PosW-1:0] position;
      logic [CntW-1:0] num;
   } emit_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LOAD,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

### src/qcsd_div.sv
module qcsd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [qcsd_pkg::CountW-1:0]   dividend,
   input  logic [qcsd_pkg::DivW-1:0]     divisor,
   output logic                          done,
   output qcsd_pkg::div_res_type         result
);

   logic [qcsd_pkg::StepW-1:0]    step_ff, step_in;
   logic                          done_ff, done_in;
   logic [qcsd_pkg::CountW-1:0]   quo_ff, quo_in;
   logic [qcsd_pkg::DivW-1:0]     rem_ff, rem_in;
   logic [qcsd_pkg::DivW-1:0]     dvs_ff, dvs_in;
   logic [qcsd_pkg::DivW:0]       trial;
   logic [qcsd_pkg::DivW:0]       diff;
   logic                          fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[qcsd_pkg::CountW-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   // Load on start, then retire one quotient bit per cycle
   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         step_in = qcsd_pkg::StepW'(qcsd_pkg::CountW);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (step_ff != '0) begin
         step_in = step_ff - qcsd_pkg::StepW'(1);
         done_in = (step_ff == qcsd_pkg::StepW'(1));
         quo_in  = {quo_ff[qcsd_pkg::CountW-2:0], fits};
         rem_in  = fits ? diff[qcsd_pkg::DivW-1:0] : trial[qcsd_pkg::DivW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done       = done_ff;
   assign result.quo = quo_ff;
   assign result.rem = rem_ff;

endmodule

### src/qcsd_emit.sv
module qcsd_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  qcsd_pkg::emit_cmd_type cmd,
   output logic                   busy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output qcsd_pkg::rsp_type      rsp_data
);

   logic [qcsd_pkg::CntW-1:0] cnt_ff, cnt_in;
   logic                      dir_ff, dir_in;
   logic [qcsd_pkg::PosW-1:0] pos_ff, pos_in;
   logic                      valid_ff, valid_in;
   qcsd_pkg::rsp_type         data_ff, data_in;
   logic                      advance;

   // Move the next event into the output register when it is free
   assign advance = (cnt_ff != '0) && (!valid_ff || !rsp_stall);

   always_comb begin
      cnt_in   = cnt_ff;
      dir_in   = dir_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         cnt_in = cmd.num;
         dir_in = cmd.direction;
         pos_in = cmd.position;
      end else if (advance) begin
         cnt_in = cnt_ff - qcsd_pkg::CntW'(1);
      end
      if (advance) begin
         valid_in           = 1'b1;
         data_in.direction  = dir_ff;
         data_in.position   = pos_ff;
         data_in.last       = (cnt_ff == qcsd_pkg::CntW'(1));
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
      dir_ff  <= dir_in;
      pos_ff  <= pos_in;
      data_ff <= data_in;
   end

   assign busy      = (cnt_ff != '0);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/quadrature_count_step_divider.sv
// Quadrature count step divider. Each sample beat (func 0) carries a raw 16-bit counter value;
// its wrapped change from the last kept sample is dropped as jitter when its magnitude is below
// dead_band, otherwise it moves the 32-bit position and a signed remainder accumulator, which is
// divided by step_divider (zero acts as one) with truncation toward zero. Each whole step gives
// one response beat with the direction and the new position, at most 16 per sample, the final
// one flagged by last. A set-position beat (func 1) loads the position, zeroes the kept sample
// and gives no response. A jitter sample ends in the check state; any other sample goes on to
// the load and divide states, and to the emit state when it yields events, its pace set by the
// bit-serial divider (one quotient bit per cycle) and by the event emitter (one beat per cycle
// when rsp_stall is low). The response output is registered, so a new request is taken while
// the last event still waits.
module quadrature_count_step_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  qcsd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output qcsd_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [0:0]                       csr_index,
   input  logic [qcsd_pkg::BandW-1:0]       csr_wdata
);

   qcsd_pkg::state_type            state_ff, state_in;
   logic [qcsd_pkg::BandW-1:0]     band_ff, band_in;
   logic [qcsd_pkg::DivW-1:0]      sdiv_ff, sdiv_in;
   logic [qcsd_pkg::CountW-1:0]    ref_ff, ref_in;
   logic [qcsd_pkg::CountW-1:0]    sample_ff, sample_in;
   logic [qcsd_pkg::CountW-1:0]    delta_ff, delta_in;
   logic [qcsd_pkg::PosW-1:0]      pos_ff, pos_in;
   logic [qcsd_pkg::CountW-1:0]    accum_ff, accum_in;

   logic                           req_take;
   logic signed [qcsd_pkg::BandW+1:0] delta_s;
   logic signed [qcsd_pkg::BandW+1:0] band_s;
   logic                           jitter;
   logic [qcsd_pkg::DivW-1:0]      div_eff;
   logic [qcsd_pkg::CountW-1:0]    accum_abs;
   logic [qcsd_pkg::CountW-1:0]    rem_ext;
   logic [qcsd_pkg::CountW-1:0]    rem_signed;
   logic                           div_start;
   logic                           div_done;
   qcsd_pkg::div_res_type          div_res;
   logic                           emit_load;
   logic                           emit_busy;
   qcsd_pkg::emit_cmd_type         emit_cmd;

   assign req_take = req_valid && !req_stall;

   // Jitter test: -dead_band < delta < dead_band
   always_comb begin
      delta_s = signed'({{(qcsd_pkg::BandW + 2 - qcsd_pkg::CountW){delta_ff[qcsd_pkg::CountW-1]}},
                         delta_ff});
      band_s  = signed'({2'b00, band_ff});
      jitter  = (delta_s > -band_s) && (delta_s < band_s);
   end

   // Divider operands and signed remainder
   always_comb begin
      div_eff    = (sdiv_ff == '0) ? qcsd_pkg::DivW'(1) : sdiv_ff;
      accum_abs  = accum_ff[qcsd_pkg::CountW-1] ? (~accum_ff + qcsd_pkg::CountW'(1)) : accum_ff;
      rem_ext    = {{(qcsd_pkg::CountW - qcsd_pkg::DivW){1'b0}}, div_res.rem};
      rem_signed = accum_ff[qcsd_pkg::CountW-1] ? (~rem_ext + qcsd_pkg::CountW'(1)) : rem_ext;
   end

   // Clamp the step count to the event limit
   always_comb begin
      emit_cmd.direction = accum_ff[qcsd_pkg::CountW-1];
      emit_cmd.position  = pos_ff;
      if (div_res.quo > qcsd_pkg::CountW'(qcsd_pkg::MaxEvents)) begin
         emit_cmd.num = qcsd_pkg::CntW'(qcsd_pkg::MaxEvents);
      end else begin
         emit_cmd.num = div_res.quo[qcsd_pkg::CntW-1:0];
      end
   end

   // Configuration writes
   always_comb begin
      band_in = band_ff;
      sdiv_in = sdiv_ff;
      if (csr_we) begin
         case (csr_index)
            qcsd_pkg::CSR_DEAD_BAND:    band_in = csr_wdata;
            qcsd_pkg::CSR_STEP_DIVIDER: sdiv_in = csr_wdata[qcsd_pkg::DivW-1:0];
            default: ;
         endcase
      end
   end

   // Datapath updates per state
   always_comb begin
      ref_in    = ref_ff;
      sample_in = sample_ff;
      delta_in  = delta_ff;
      pos_in    = pos_ff;
      accum_in  = accum_ff;
      case (state_ff)
         qcsd_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_data.func == qcsd_pkg::FUNC_SET_POS) begin
                  pos_in = req_data.new_position;
                  ref_in = '0;
               end else begin
                  sample_in = req_data.count;
                  delta_in  = req_data.count - ref_ff;
               end
            end
         end
         qcsd_pkg::ST_CHECK: begin
            if (!jitter) begin
               ref_in   = sample_ff;
               pos_in   = pos_ff + {{(qcsd_pkg::PosW - qcsd_pkg::CountW)
                                     {delta_ff[qcsd_pkg::CountW-1]}}, delta_ff};
               accum_in = accum_ff + delta_ff;
            end
         end
         qcsd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               accum_in = rem_signed;
            end
         end
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qcsd_pkg::ST_IDLE: begin
            if (req_take && req_data.func == qcsd_pkg::FUNC_SAMPLE) begin
               state_in = qcsd_pkg::ST_CHECK;
            end
         end
         qcsd_pkg::ST_CHECK:  state_in = jitter ? qcsd_pkg::ST_IDLE : qcsd_pkg::ST_LOAD;
         qcsd_pkg::ST_LOAD:   state_in = qcsd_pkg::ST_DIVIDE;
         qcsd_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = (div_res.quo == '0) ? qcsd_pkg::ST_IDLE : qcsd_pkg::ST_EMIT;
            end
         end
         qcsd_pkg::ST_EMIT: begin
            if (!emit_busy) begin
               state_in = qcsd_pkg::ST_IDLE;
            end
         end
         default: state_in = qcsd_pkg::ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      emit_load = 1'b0;
      case (state_ff)
         qcsd_pkg::ST_IDLE:   req_stall = 1'b0;
         qcsd_pkg::ST_LOAD:   div_start = 1'b1;
         qcsd_pkg::ST_DIVIDE: emit_load = div_done && (div_res.quo != '0);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= qcsd_pkg::ST_IDLE;
         band_ff  <= qcsd_pkg::DeadBandReset;
         sdiv_ff  <= qcsd_pkg::StepDividerReset;
         ref_ff   <= '0;
         pos_ff   <= '0;
         accum_ff <= '0;
      end else begin
         state_ff <= state_in;
         band_ff  <= band_in;
         sdiv_ff  <= sdiv_in;
         ref_ff   <= ref_in;
         pos_ff   <= pos_in;
         accum_ff <= accum_in;
      end
      sample_ff <= sample_in;
      delta_ff  <= delta_in;
   end

   qcsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (accum_abs),
      .divisor  (div_eff),
      .done     (div_done),
      .result   (div_res)
   );

   qcsd_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (emit_load),
      .cmd       (emit_cmd),
      .busy      (emit_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // The divider raises done once it has retired every quotient bit of a started division
   a_div_latency: assert property (@(posedge clock) disable iff (reset)
      div_start |-> ##17 div_done)
      else $error("divider did not finish on time");

   // Events are only pending while the sequencer waits for them
   a_emit_state: assert property (@(posedge clock) disable iff (reset)
      emit_busy |-> (state_ff == qcsd_pkg::ST_EMIT))
      else $error("event burst pending outside emit state");

   // A taken beat that is not the last of its burst is followed at once by the next
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last) |=> rsp_valid)
      else $error("gap inside an event burst");

endmodule
